[rtl/aes_pkg.sv]
// shared constants, types and round functions for the aes-128 encrypt pipeline
package aes_pkg;

	localparam int NumRounds = 10;
	localparam int BlockW = 128;
	localparam int HalfW = 64;

	typedef logic [7:0] byte_t;
	typedef logic [31:0] word_t;
	typedef logic [BlockW-1:0] block_t;

	function automatic byte_t sbox(input byte_t a);
		byte_t r;
		case (a)
			8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
			8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
			8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
			8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
			8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
			8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
			8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
			8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
			8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
			8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
			8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
			8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
			8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
			8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
			8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
			8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
			8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
			8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
			8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
			8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
			8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
			8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
			8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
			8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
			8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
			8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
			8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
			8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
			8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
			8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
			8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
			8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
			8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
			8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
			8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
			8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
			8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
			8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
			8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
			8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
			8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
			8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
			8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
			8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
			8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
			8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
			8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
			8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
			8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
			8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
			8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
			8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
			8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
			8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
			8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
			8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
			8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
			8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
			8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
			8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
			8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
			8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
			8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
			8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic byte_t rcon(input logic [3:0] rnd);
		byte_t r;
		case (rnd)
			4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
			4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
			4'd9: r = 8'h1b; 4'd10: r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic byte_t xtime(input byte_t b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	// byte n of the block sits at bits 127-8n
	function automatic byte_t get_b(input block_t s, input int n);
		return s[BlockW-1-8*n -: 8];
	endfunction

	function automatic block_t next_key(input block_t k, input logic [3:0] rnd);
		word_t t;
		block_t r;
		t = k[31:0];
		t = {sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0]), sbox(t[31:24])}
			^ {rcon(rnd), 24'h0};
		r[127:96] = k[127:96] ^ t;
		r[95:64] = k[95:64] ^ r[127:96];
		r[63:32] = k[63:32] ^ r[95:64];
		r[31:0] = k[31:0] ^ r[63:32];
		return r;
	endfunction

	function automatic block_t enc_round(input block_t s, input block_t k, input logic last);
		block_t t;
		block_t m;
		byte_t a0, a1, a2, a3, al;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[BlockW-1-8*(4*c+r) -: 8] = sbox(get_b(s, 4*((c+r)%4)+r));
			end
		end
		m = t;
		for (int c = 0; c < 4; c++) begin
			a0 = get_b(t, 4*c);
			a1 = get_b(t, 4*c+1);
			a2 = get_b(t, 4*c+2);
			a3 = get_b(t, 4*c+3);
			al = a0 ^ a1 ^ a2 ^ a3;
			m[BlockW-1-8*(4*c) -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			m[BlockW-1-8*(4*c+1) -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			m[BlockW-1-8*(4*c+2) -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			m[BlockW-1-8*(4*c+3) -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		return (last ? t : m) ^ k;
	endfunction

endpackage

[rtl/aes128_block_encrypt_unit.sv]
// aes-128 encryption pipeline, one round and one key step per stage after s0
// Encrypts one 128-bit block with its own 128-bit key per word. Stage s0 applies the
// initial round key; stages s1 to s10 each run one round (s10 the final one, without
// MixColumns) and derive the next round key in parallel, and a new word is taken every
// cycle while the chain is not stalled. Every stage advances when the next one is empty
// or moving, so backpressure stalls the stages from the output back to the first bubble.
// Input tdata from bit 0: text_hi, text_lo, key_hi, key_lo; output: cipher_hi, cipher_lo.
module aes128_block_encrypt_unit
	import aes_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [4*HalfW-1:0] s_tdata, // text_hi, text_lo, key_hi, key_lo
	output logic m_tvalid,
	input  logic m_tready,
	output logic [2*HalfW-1:0] m_tdata // cipher_hi, cipher_lo
);

	localparam int NumStages = NumRounds + 1;

	logic [NumStages-1:0] vld_s;
	block_t st_s [NumStages];
	block_t ky_s [NumStages];
	logic [NumStages-1:0] adv;

	block_t in_text, in_key;

	assign in_text = {s_tdata[HalfW-1:0], s_tdata[2*HalfW-1:HalfW]};
	assign in_key = {s_tdata[3*HalfW-1:2*HalfW], s_tdata[4*HalfW-1:3*HalfW]};

	always_comb begin
		adv[NumStages-1] = !vld_s[NumStages-1] || m_tready;
		for (int i = NumStages-2; i >= 0; i--) begin
			adv[i] = !vld_s[i] || adv[i+1];
		end
	end

	assign s_tready = adv[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) vld_s[0] <= s_tvalid;
			for (int i = 1; i < NumStages; i++) begin
				if (adv[i]) vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			st_s[0] <= in_text ^ in_key;
			ky_s[0] <= in_key;
		end
		for (int i = 1; i < NumStages; i++) begin
			if (adv[i]) begin
				st_s[i] <= enc_round(st_s[i-1], next_key(ky_s[i-1], 4'(i)),
					i == NumRounds);
				ky_s[i] <= next_key(ky_s[i-1], 4'(i));
			end
		end
	end

	assign m_tvalid = vld_s[NumStages-1];
	assign m_tdata = {st_s[NumStages-1][HalfW-1:0], st_s[NumStages-1][2*HalfW-1:HalfW]};

`ifndef SYNTH
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word changed under backpressure");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("pipeline stalled with empty output stage");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tready |=> vld_s[0])
		else $error("accepted word not captured");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |=> $countones(vld_s) <= $countones($past(vld_s)) + 1)
		else $error("pipeline word count grew by more than one");
`endif

endmodule
